>>> src/pphm_pkg.sv
// ----------------------------------------------------------------------------
// pphm_pkg
// Shared types and constants for the perturb-probe hash map core.
// ----------------------------------------------------------------------------
package pphm_pkg;

    localparam int SLOTS       = 1024;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int POS_W       = IDX_W + 1;
    localparam int PROBE_LIMIT = SLOTS + 16;
    localparam int CNT_W       = $clog2(PROBE_LIMIT);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int BUDGET_W    = 13;
    localparam int BUDGET_INIT = 4 * SLOTS + 1;
    localparam int BUDGET_STEP = 6;
    localparam int PERTURB_SH  = 5;

    // RAM word: {used, key, value}
    localparam int WORD_W      = 1 + KEY_W + VAL_W;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W   = ((KEY_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_W + KEY_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int TUSER_W     = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ITER  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_EXIST   = 2'd0,
        STAT_CREATED = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_ENDED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

>>> src/perturb_probe_hash_map_core.sv
// ----------------------------------------------------------------------------
// perturb_probe_hash_map_core
// Open-addressed 64-bit key to 64-bit value map with perturbed probing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser holds the op (read, write,
//   iterate, no-op), s_tdata holds key, write value and start position.
//   One result per request leaves on the m_ channel: m_tuser holds the
//   status, m_tdata holds slot, key, value and next position.
//   One request is in work at a time; s_tready is low while it runs.
//   A lookup does one RAM read per slot probed, and an iteration one per
//   slot scanned. A no-op or an iteration starting beyond the last slot
//   examines no slot and goes straight to its result.
//   The single-port slot RAM sets the pace: one slot is examined per cycle.
//   Reset: after aresetn is released a clearing pass writes all 1024 slots,
//   one per cycle; s_tready stays low until the pass ends.
//   Stall: the result sits in an output register; the next request is taken
//   while it waits, and a later result holds until m_tready frees the
//   register.
// ----------------------------------------------------------------------------
module perturb_probe_hash_map_core import pphm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: key[63:0], write_value[127:64], start_position[138:128]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: op[1:0]
    input  logic [TUSER_W-1:0]   s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: slot[9:0], key_out[73:10], value_out[137:74],
    //          next_position[148:138]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [TUSER_W-1:0]   m_tuser
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic                out_valid_reg, out_valid_next;

    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    wval_reg, wval_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0]    perturb_reg, perturb_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [VAL_W-1:0]    res_value_reg, res_value_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;

    status_t             out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_slot_reg, out_slot_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    op_t                 in_op;
    logic [KEY_W-1:0]    in_key;
    logic [VAL_W-1:0]    in_wval;
    logic [POS_W-1:0]    in_pos;
    logic                accept;

    logic                rd_used;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic                hit;
    logic                probe_last;
    logic                scan_last;
    logic [KEY_W-1:0]    perturb_adv;
    logic [IDX_W-1:0]    idx_step;
    logic [VAL_W-1:0]    new_value;

    assign in_op   = op_t'(s_tuser);
    assign in_key  = s_tdata[KEY_W-1:0];
    assign in_wval = s_tdata[KEY_W+VAL_W-1:KEY_W];
    assign in_pos  = s_tdata[KEY_W+VAL_W+POS_W-1:KEY_W+VAL_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign rd_used = ram_rdata[WORD_W-1];
    assign rd_key  = ram_rdata[KEY_W+VAL_W-1:VAL_W];
    assign rd_val  = ram_rdata[VAL_W-1:0];
    assign hit     = rd_used && (rd_key == key_reg);

    assign probe_last  = (cnt_reg == CNT_W'(PROBE_LIMIT - 1));
    assign scan_last   = (idx_reg == IDX_W'(SLOTS - 1));
    // perturb shifts only from the second miss on
    assign perturb_adv = (cnt_reg != '0) ? (perturb_reg >> PERTURB_SH) : perturb_reg;
    assign idx_step    = {idx_reg[IDX_W-3:0], 2'b00} + idx_reg
                         + perturb_adv[IDX_W-1:0] + IDX_W'(1);
    assign new_value   = (op_reg == OP_WRITE) ? wval_reg : rd_val;

    pphm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_NOP || (in_op == OP_ITER && in_pos[IDX_W])) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (op_reg == OP_ITER) begin
                    if (rd_used || scan_last) begin
                        state_next = ST_DONE;
                    end
                end else if (!rd_used || hit || probe_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        clr_next        = clr_reg;
        budget_next     = budget_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        op_next         = op_reg;
        key_next        = key_reg;
        wval_next       = wval_reg;
        idx_next        = idx_reg;
        perturb_next    = perturb_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_key_next    = res_key_reg;
        res_value_next  = res_value_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next      = in_op;
                    key_next     = in_key;
                    wval_next    = in_wval;
                    perturb_next = in_key;
                    cnt_next     = '0;
                    idx_next     = (in_op == OP_ITER) ? in_pos[IDX_W-1:0]
                                                      : in_key[IDX_W-1:0];
                    ram_addr     = idx_next;
                    res_status_next = STAT_ENDED;
                    res_slot_next   = '0;
                    res_key_next    = '0;
                    res_value_next  = '0;
                    res_pos_next    = (in_op == OP_ITER) ? POS_W'(SLOTS) : '0;
                end
            end
            ST_CHECK: begin
                if (op_reg == OP_ITER) begin
                    if (rd_used) begin
                        res_status_next = STAT_EXIST;
                        res_slot_next   = idx_reg;
                        res_key_next    = rd_key;
                        res_value_next  = rd_val;
                        res_pos_next    = {1'b0, idx_reg} + POS_W'(1);
                    end else if (scan_last) begin
                        res_status_next = STAT_ENDED;
                        res_slot_next   = '0;
                        res_key_next    = '0;
                        res_value_next  = '0;
                        res_pos_next    = POS_W'(SLOTS);
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                        ram_addr = idx_next;
                    end
                end else begin
                    res_key_next = key_reg;
                    res_pos_next = '0;
                    if (hit) begin
                        res_status_next = STAT_EXIST;
                        res_slot_next   = idx_reg;
                        res_value_next  = new_value;
                        ram_we          = (op_reg == OP_WRITE);
                        ram_wdata       = {1'b1, key_reg, wval_reg};
                    end else if (!rd_used &&
                                 budget_reg > BUDGET_W'(BUDGET_STEP)) begin
                        // create the entry; a write stores its value at once
                        res_status_next = STAT_CREATED;
                        res_slot_next   = idx_reg;
                        res_value_next  = (op_reg == OP_WRITE) ? wval_reg : '0;
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, key_reg, res_value_next};
                        budget_next     = budget_reg - BUDGET_W'(BUDGET_STEP);
                    end else if (!rd_used || probe_last) begin
                        res_status_next = STAT_FULL;
                        res_slot_next   = '0;
                        res_value_next  = '0;
                    end else begin
                        idx_next     = idx_step;
                        perturb_next = perturb_adv;
                        cnt_next     = cnt_reg + CNT_W'(1);
                        ram_addr     = idx_step;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_key_next    = res_key_reg;
                    out_value_next  = res_value_reg;
                    out_pos_next    = res_pos_reg;
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            budget_reg    <= BUDGET_W'(BUDGET_INIT);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            budget_reg    <= budget_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        wval_reg       <= wval_next;
        idx_reg        <= idx_next;
        perturb_reg    <= perturb_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_key_reg    <= res_key_next;
        res_value_reg  <= res_value_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - KEY_W - VAL_W - POS_W){1'b0}},
                       out_pos_reg, out_value_reg, out_key_reg, out_slot_reg};

endmodule

>>> src/pphm_ram.sv
// ----------------------------------------------------------------------------
// pphm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/pphm_checker.sv
// ----------------------------------------------------------------------------
// pphm_checker
// Port-level assertions for the perturb-probe hash map core.
// ----------------------------------------------------------------------------
module pphm_checker import pphm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [TUSER_W-1:0]   s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0]   m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_ended_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_ENDED |->
            m_tdata[IDX_W+KEY_W+VAL_W-1:0] == '0)
        else $error("ended result carries data");

    a_full_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_FULL |->
            m_tdata[IDX_W-1:0] == '0 &&
            m_tdata[IDX_W+KEY_W+VAL_W+POS_W-1:IDX_W+KEY_W] == '0)
        else $error("full result carries slot, value or position");

endmodule

bind perturb_probe_hash_map_core pphm_checker u_pphm_checker (.*);

>>> dv/tb_perturb_probe_hash_map_core.sv
// ----------------------------------------------------------------------------
// tb_perturb_probe_hash_map_core
// Self-checking bench for the perturb-probe hash map core.
// ----------------------------------------------------------------------------
// A local map model tracks slot occupancy, keys, values and the load budget.
// Every accepted request updates it and queues the response it should cause.
// A monitor compares each response, field by field, with the oldest queued
// one. The tests cover corner requests, random traffic with colliding keys,
// a long result stall, filling the table until it refuses new keys, and
// traffic on the full table. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_perturb_probe_hash_map_core;
    import pphm_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int QUIET_CYCLES = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 40;

    typedef enum {PROBE_FOUND, PROBE_ABSENT, PROBE_GAVE_UP} probe_outcome_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  slot;
        logic [KEY_W-1:0]  key_out;
        logic [VAL_W-1:0]  value_out;
        logic [POS_W-1:0]  next_pos;
    } map_response_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [TUSER_W-1:0]   s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0]   m_tuser;

    // model of the table
    bit                   map_used [SLOTS];
    logic [KEY_W-1:0]     map_key  [SLOTS];
    logic [VAL_W-1:0]     map_val  [SLOTS];
    int unsigned          map_budget = BUDGET_INIT;
    logic [KEY_W-1:0]     stored_keys[$];

    map_response_t        awaited_responses[$];
    int unsigned          mismatch_count = 0;
    int unsigned          responses_seen = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          hold_off_cycles = 0;
    bit                   calm_mode = 1'b0;

    int unsigned          n_created, n_hits, n_full, n_scan_found, n_scan_ended, n_nops;

    perturb_probe_hash_map_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic probe_outcome_t locate_key(input logic [KEY_W-1:0] key,
                                                  output int unsigned where);
        logic [63:0] idx;
        logic [63:0] perturb;
        idx     = key & 64'(SLOTS - 1);
        perturb = key;
        for (int n = 0; n < PROBE_LIMIT; n++) begin
            if (!map_used[idx[IDX_W-1:0]]) begin
                where = 32'(idx[IDX_W-1:0]);
                return PROBE_ABSENT;
            end
            if (map_key[idx[IDX_W-1:0]] == key) begin
                where = 32'(idx[IDX_W-1:0]);
                return PROBE_FOUND;
            end
            if (n > 0)
                perturb = perturb >> PERTURB_SH;
            idx = ((idx << 2) + idx + perturb + 64'd1) & 64'(SLOTS - 1);
        end
        where = 0;
        return PROBE_GAVE_UP;
    endfunction

    // Update the table model for one request and return the response it causes.
    function automatic map_response_t map_apply(op_t op, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] wval,
                                                logic [POS_W-1:0] pos);
        map_response_t  resp;
        probe_outcome_t outcome;
        int unsigned    where;
        resp.status    = STAT_ENDED;
        resp.slot      = '0;
        resp.key_out   = '0;
        resp.value_out = '0;
        resp.next_pos  = '0;
        case (op)
            OP_ITER: begin
                resp.next_pos = POS_W'(SLOTS);
                for (int p = int'(pos); p < SLOTS; p++) begin
                    if (map_used[p]) begin
                        resp.status    = STAT_EXIST;
                        resp.slot      = IDX_W'(p);
                        resp.key_out   = map_key[p];
                        resp.value_out = map_val[p];
                        resp.next_pos  = POS_W'(p + 1);
                        n_scan_found++;
                        return resp;
                    end
                end
                n_scan_ended++;
            end
            OP_NOP: begin
                n_nops++;
            end
            default: begin
                resp.key_out = key;
                outcome = locate_key(key, where);
                if (outcome == PROBE_GAVE_UP ||
                    (outcome == PROBE_ABSENT && map_budget <= BUDGET_STEP)) begin
                    resp.status = STAT_FULL;
                    n_full++;
                    return resp;
                end
                if (outcome == PROBE_ABSENT) begin
                    map_used[where] = 1'b1;
                    map_key[where]  = key;
                    map_val[where]  = '0;
                    map_budget      = map_budget - BUDGET_STEP;
                    stored_keys.push_back(key);
                    resp.status = STAT_CREATED;
                    n_created++;
                end else begin
                    resp.status = STAT_EXIST;
                    n_hits++;
                end
                if (op == OP_WRITE)
                    map_val[where] = wval;
                resp.slot      = IDX_W'(where);
                resp.value_out = map_val[where];
            end
        endcase
        return resp;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Draw a key not yet in the table; some share low bits to build probe chains.
    function automatic logic [KEY_W-1:0] unused_key();
        logic [KEY_W-1:0] k;
        int unsigned      where;
        do begin
            k = {$urandom, $urandom};
            case ($urandom_range(3))
                0: k[IDX_W-1:0] = IDX_W'($urandom_range(7) * 37);
                1: k = k & 64'h3FFF;
                default: ;
            endcase
        end while (locate_key(k, where) == PROBE_FOUND);
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] data_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [POS_W-1:0] scan_start();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return POS_W'($urandom_range(SLOTS - 1));
        if (r < 85)
            return POS_W'($urandom_range(SLOTS - 24, SLOTS - 1));
        return POS_W'($urandom_range(SLOTS, 2 * SLOTS - 1));
    endfunction

    // Offer one request, hold it until accepted, then idle for a random gap.
    task automatic send_request(op_t op, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] wval, logic [POS_W-1:0] pos);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({pos, wval, key});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        awaited_responses.push_back(map_apply(op, key, wval, pos));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_responses.size() != 0)
            @(posedge aclk);
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH response %0d %s: got %h, want %h",
                     responses_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : response_check
        map_response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_responses.size() == 0) begin
                flag_mismatch("with nothing pending", 64'(m_tuser), 64'd0);
            end else begin
                want = awaited_responses.pop_front();
                if (m_tuser[1:0] != want.status)
                    flag_mismatch("status", 64'(m_tuser[1:0]), 64'(want.status));
                if (m_tdata[IDX_W-1:0] != want.slot)
                    flag_mismatch("slot", 64'(m_tdata[IDX_W-1:0]), 64'(want.slot));
                if (m_tdata[IDX_W +: KEY_W] != want.key_out)
                    flag_mismatch("key_out", m_tdata[IDX_W +: KEY_W], want.key_out);
                if (m_tdata[IDX_W+KEY_W +: VAL_W] != want.value_out)
                    flag_mismatch("value_out", m_tdata[IDX_W+KEY_W +: VAL_W],
                                  want.value_out);
                if (m_tdata[IDX_W+KEY_W+VAL_W +: POS_W] != want.next_pos)
                    flag_mismatch("next_position",
                                  64'(m_tdata[IDX_W+KEY_W+VAL_W +: POS_W]),
                                  64'(want.next_pos));
            end
            responses_seen++;
        end
    end

    initial begin : result_sink
        int unsigned idle_left;
        idle_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else begin
                m_tready <= 1'b1;
                idle_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d responses pending",
                 cycle_count, awaited_responses.size());
        $display("** perturb_probe_hash_map_core: FAILED **");
        $finish;
    end

    task automatic test_corner_requests();
        calm_mode = 1'b1;
        send_request(OP_READ,  64'd0, 64'h1234, 11'd0);            // create at slot 0
        send_request(OP_WRITE, 64'd0, '1, 11'd2047);               // hit, replace value
        send_request(OP_READ,  '1, '0, 11'd1024);                  // create at last slot
        send_request(OP_WRITE, 64'd1024, 64'h0123_4567_89AB_CDEF, '0); // collides with key 0
        send_request(OP_WRITE, 64'd2048, '0, 11'd5);               // longer chain
        send_request(OP_READ,  64'd1024, '1, '1);
        send_request(OP_WRITE, '1, '0, '0);                        // write zero to a hit
        calm_mode = 1'b0;
        send_request(OP_ITER,  '1, '1, 11'd0);
        send_request(OP_ITER,  '0, '0, 11'd1);
        send_request(OP_ITER,  '0, '0, 11'd1023);
        send_request(OP_ITER,  '0, '0, 11'd1024);                  // start past the end
        send_request(OP_ITER,  '1, '1, 11'd2047);
        send_request(OP_NOP,   '1, '1, '1);
        send_request(OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '1);
        send_request(OP_READ,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(OP_WRITE, 64'h5555_5555_5555_5555, '1, 11'd1024);
        send_request(OP_NOP,   '0, '0, '0);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned      r;
        op_t              rw_op;
        logic [KEY_W-1:0] key;
        for (int unsigned n = 0; n < count; n++) begin
            // run a calm stretch now and then
            if (n % 200 == 0)
                calm_mode = 1'b1;
            else if (n % 200 == 40)
                calm_mode = 1'b0;
            r     = $urandom_range(99);
            rw_op = op_t'($urandom_range(1));
            if (r < 35 || (r < 70 && stored_keys.size() == 0)) begin
                send_request(rw_op, unused_key(), data_word(), POS_W'($urandom));
            end else if (r < 70) begin
                key = stored_keys[$urandom_range(stored_keys.size() - 1)];
                send_request(rw_op, key, data_word(), POS_W'($urandom));
            end else if (r < 92) begin
                send_request(OP_ITER, {$urandom, $urandom}, data_word(), scan_start());
            end else if (r < 96) begin
                send_request(OP_NOP, {$urandom, $urandom}, data_word(), POS_W'($urandom));
            end else begin
                send_request(rw_op, {$urandom, $urandom}, data_word(), POS_W'($urandom));
            end
        end
        calm_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off_cycles = HOLD_CYCLES;
        // keep offering while the result side is held off
        calm_mode = 1'b1;
        for (int n = 0; n < 30; n++)
            send_request(op_t'($urandom_range(1)), unused_key(), data_word(), '0);
        calm_mode = 1'b0;
        wait_for_drain();
        for (int n = 0; n < 10; n++)
            send_request(OP_ITER, '0, '0, scan_start());
        wait_for_drain();
    endtask

    task automatic test_fill_to_capacity();
        while (map_budget > BUDGET_STEP)
            send_request(op_t'($urandom_range(1)), unused_key(), data_word(),
                         POS_W'($urandom));
        // table now refuses new keys, on reads and writes alike
        for (int n = 0; n < 6; n++)
            send_request(op_t'(n % 2), unused_key(), '1, '0);
    endtask

    initial begin : run_tests
        n_created    = 0;
        n_hits       = 0;
        n_full       = 0;
        n_scan_found = 0;
        n_scan_ended = 0;
        n_nops       = 0;
        for (int i = 0; i < SLOTS; i++)
            map_used[i] = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_requests();
        test_random_traffic(70);
        test_backpressure();
        test_fill_to_capacity();
        test_random_traffic(30);

        wait_for_drain();
        repeat (QUIET_CYCLES) @(posedge aclk);

        $display("Checked %0d responses in %0d cycles: %0d created, %0d hits, %0d full",
                 responses_seen, cycle_count, n_created, n_hits, n_full);
        $display("Scans found %0d entries and ran off the end %0d times; %0d no-ops",
                 n_scan_found, n_scan_ended, n_nops);
        if (mismatch_count == 0) begin
            $display("** perturb_probe_hash_map_core: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** perturb_probe_hash_map_core: FAILED **");
        end
        $finish;
    end

endmodule
